### design/gtsc_pkg.sv
// ----------------------------------------------------------------------------
// gtsc_pkg
// Shared types, widths and the tanh segment table for the gain and tanh
// soft clipper datapath.
// ----------------------------------------------------------------------------
package gtsc_pkg;

    localparam int TANH_SEGMENTS = 64;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 16;
    localparam int MAG_W    = 32;
    localparam int U_W      = MAG_W + GAIN_W - 1;
    localparam int IDX_W    = $clog2(TANH_SEGMENTS + 1);
    localparam int POS_W    = U_W + IDX_W;
    localparam int K_LSB    = 42;
    localparam int K_W      = POS_W - K_LSB;
    localparam int FRAC_W   = 16;
    localparam int FRAC_LSB = K_LSB - FRAC_W;
    localparam int Y_W      = 31;
    localparam int PRODF_W  = Y_W + FRAC_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [Y_W-1:0]    FULL_SCALE = {Y_W{1'b1}};
    localparam logic [PRODF_W-1:0] ROUND_HALF = PRODF_W'(1) << (FRAC_W - 1);

    // series argument 16/N in Q31
    localparam logic [63:0] TANH_Z = (64'd1 << 35) / 64'(TANH_SEGMENTS);

    typedef logic [TANH_SEGMENTS:0][Y_W-1:0] tanh_rom_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       end_of_buffer;
    } sample_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       end_of_result;
    } sample_out_t;

    typedef struct packed {
        logic [U_W-1:0] u;
        logic           neg;
        logic           eob;
    } scaled_t;

    typedef struct packed {
        logic [Y_W-1:0]    lo;
        logic [Y_W-1:0]    diff;
        logic [FRAC_W-1:0] frac;
        logic              over;
        logic              neg;
        logic              eob;
    } segment_t;

    // restoring shift-subtract quotient, evaluated at elaboration only
    function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], dividend[b]};
            if (rem >= {1'b0, divisor})
            begin
                rem    = rem - {1'b0, divisor};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(8k/N) in Q31 from a decaying exponential ladder
    function automatic tanh_rom_t build_tanh_rom();
        logic [63:0] q31_one;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] t;
        tanh_rom_t   rom;
        q31_one = 64'd1 << 31;
        z       = TANH_Z;
        if (z > q31_one)
        begin
            z = q31_one;
        end
        term    = q31_one;
        pos_sum = q31_one;
        neg_sum = 64'd0;
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64((term * z) >> 31, 64'(n));
            if ((n & 1) == 1)
            begin
                neg_sum = neg_sum + term;
            end
            else
            begin
                pos_sum = pos_sum + term;
            end
        end
        d = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
        e = q31_one;
        for (int k = 0; k <= TANH_SEGMENTS; k++)
        begin
            num = (q31_one - e) << 31;
            t   = udiv64(num, q31_one + e);
            if (t > 64'(FULL_SCALE))
            begin
                t = 64'(FULL_SCALE);
            end
            rom[k] = t[Y_W-1:0];
            e = (e * d + (64'd1 << 30)) >> 31;
            if (e > q31_one)
            begin
                e = q31_one;
            end
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

### design/gtsc_front.sv
// ----------------------------------------------------------------------------
// gtsc_front
// Magnitude and sign split of the input sample, then the gain multiply.
// Two register stages.
// ----------------------------------------------------------------------------
module gtsc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gtsc_pkg::GAIN_W-1:0]   gain,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  gtsc_pkg::sample_in_t          up_data,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output gtsc_pkg::scaled_t             dn_data
);

    logic                         s1_valid_reg;
    logic [gtsc_pkg::MAG_W-1:0]   s1_mag_reg;
    logic                         s1_neg_reg;
    logic                         s1_eob_reg;
    logic [gtsc_pkg::MAG_W-1:0]   s1_mag_next;
    logic                         s1_ready;

    logic                         s2_valid_reg;
    gtsc_pkg::scaled_t            s2_data_reg;
    gtsc_pkg::scaled_t            s2_data_next;
    logic                         s2_ready;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    assign s1_mag_next = up_data.sample_in[gtsc_pkg::SAMPLE_W-1]
                       ? (~up_data.sample_in) + gtsc_pkg::MAG_W'(1)
                       : up_data.sample_in;

    always_comb
    begin
        s2_data_next.u   = gtsc_pkg::U_W'(s1_mag_reg) * gtsc_pkg::U_W'(gain);
        s2_data_next.neg = s1_neg_reg;
        s2_data_next.eob = s1_eob_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_mag_reg <= s1_mag_next;
            s1_neg_reg <= up_data.sample_in[gtsc_pkg::SAMPLE_W-1];
            s1_eob_reg <= up_data.end_of_buffer;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

endmodule

### design/gtsc_lookup.sv
// ----------------------------------------------------------------------------
// gtsc_lookup
// Table position from the scaled magnitude: segment index, fraction,
// range check and the two neighbouring tanh points. One register stage.
// ----------------------------------------------------------------------------
module gtsc_lookup (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  gtsc_pkg::scaled_t    up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output gtsc_pkg::segment_t   dn_data
);

    logic [gtsc_pkg::POS_W-1:0]  pos;
    logic [gtsc_pkg::K_W-1:0]    k_full;
    logic                        over;
    logic [gtsc_pkg::IDX_W-1:0]  idx;
    logic [gtsc_pkg::IDX_W-1:0]  idx_hi;
    logic [gtsc_pkg::Y_W-1:0]    lo;
    logic [gtsc_pkg::Y_W-1:0]    hi;

    logic                        s3_valid_reg;
    gtsc_pkg::segment_t          s3_data_reg;
    gtsc_pkg::segment_t          s3_data_next;
    logic                        s3_ready;

    assign s3_ready = !s3_valid_reg || dn_ready;
    assign up_ready = s3_ready;

    assign pos    = gtsc_pkg::POS_W'(up_data.u) * gtsc_pkg::POS_W'(gtsc_pkg::TANH_SEGMENTS);
    assign k_full = pos[gtsc_pkg::POS_W-1:gtsc_pkg::K_LSB];
    assign over   = k_full >= gtsc_pkg::K_W'(gtsc_pkg::TANH_SEGMENTS);
    assign idx    = over ? '0 : k_full[gtsc_pkg::IDX_W-1:0];
    assign idx_hi = idx + gtsc_pkg::IDX_W'(1);
    assign lo     = gtsc_pkg::TANH_ROM[idx];
    assign hi     = gtsc_pkg::TANH_ROM[idx_hi];

    always_comb
    begin
        s3_data_next.frac = pos[gtsc_pkg::FRAC_LSB +: gtsc_pkg::FRAC_W];
        s3_data_next.over = over;
        s3_data_next.neg  = up_data.neg;
        s3_data_next.eob  = up_data.eob;
        if (over)
        begin
            s3_data_next.lo   = gtsc_pkg::FULL_SCALE;
            s3_data_next.diff = '0;
        end
        else
        begin
            s3_data_next.lo   = lo;
            s3_data_next.diff = (hi > lo) ? hi - lo : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign dn_data  = s3_data_reg;

    a_over_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_data_reg.over |->
            s3_data_reg.diff == '0 && s3_data_reg.lo == gtsc_pkg::FULL_SCALE)
        else $error("out-of-range segment without full-scale point");

endmodule

### design/gtsc_interp.sv
// ----------------------------------------------------------------------------
// gtsc_interp
// Linear interpolation between tanh points, cap at full scale and sign
// restore. Three register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module gtsc_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  gtsc_pkg::segment_t    up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output gtsc_pkg::sample_out_t dn_data
);

    logic                           s4_valid_reg;
    logic [gtsc_pkg::PRODF_W-1:0]   s4_prod_reg;
    logic [gtsc_pkg::Y_W-1:0]       s4_lo_reg;
    logic                           s4_neg_reg;
    logic                           s4_eob_reg;
    logic [gtsc_pkg::PRODF_W-1:0]   s4_prod_next;
    logic                           s4_ready;

    logic                           s5_valid_reg;
    logic [gtsc_pkg::Y_W-1:0]       s5_y_reg;
    logic                           s5_neg_reg;
    logic                           s5_eob_reg;
    logic [gtsc_pkg::PRODF_W-1:0]   rounded_sum;
    logic [gtsc_pkg::Y_W:0]         y_sum;
    logic [gtsc_pkg::Y_W-1:0]       s5_y_next;
    logic                           s5_ready;

    logic                           s6_valid_reg;
    gtsc_pkg::sample_out_t          s6_data_reg;
    gtsc_pkg::sample_out_t          s6_data_next;
    logic [gtsc_pkg::SAMPLE_W-1:0]  y_ext;
    logic                           s6_ready;

    assign s6_ready = !s6_valid_reg || dn_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign up_ready = s4_ready;

    assign s4_prod_next = gtsc_pkg::PRODF_W'(up_data.diff) * gtsc_pkg::PRODF_W'(up_data.frac);

    assign rounded_sum = s4_prod_reg + gtsc_pkg::ROUND_HALF;
    assign y_sum       = {1'b0, s4_lo_reg}
                       + {1'b0, rounded_sum[gtsc_pkg::FRAC_W +: gtsc_pkg::Y_W]};
    assign s5_y_next   = y_sum[gtsc_pkg::Y_W] ? gtsc_pkg::FULL_SCALE : y_sum[gtsc_pkg::Y_W-1:0];

    assign y_ext = {1'b0, s5_y_reg};

    always_comb
    begin
        s6_data_next.sample_out    = s5_neg_reg ? (~y_ext) + gtsc_pkg::SAMPLE_W'(1) : y_ext;
        s6_data_next.end_of_result = s5_eob_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= up_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && up_valid)
        begin
            s4_prod_reg <= s4_prod_next;
            s4_lo_reg   <= up_data.lo;
            s4_neg_reg  <= up_data.neg;
            s4_eob_reg  <= up_data.eob;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_y_reg   <= s5_y_next;
            s5_neg_reg <= s4_neg_reg;
            s5_eob_reg <= s4_eob_reg;
        end
        if (s6_ready && s5_valid_reg)
        begin
            s6_data_reg <= s6_data_next;
        end
    end

    assign dn_valid = s6_valid_reg;
    assign dn_data  = s6_data_reg;

    a_no_most_negative: assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg |-> s6_data_reg.sample_out != {1'b1, {(gtsc_pkg::SAMPLE_W-1){1'b0}}})
        else $error("output beat outside symmetric range");

    a_positive_sign: assert property (@(posedge clk) disable iff (!rst_n)
        s6_ready && s5_valid_reg && !s5_neg_reg |=> !s6_data_reg.sample_out[gtsc_pkg::SAMPLE_W-1])
        else $error("positive input gave negative output");

    a_negative_sign: assert property (@(posedge clk) disable iff (!rst_n)
        s6_ready && s5_valid_reg && s5_neg_reg && s5_y_reg != '0 |=>
            s6_data_reg.sample_out[gtsc_pkg::SAMPLE_W-1])
        else $error("negative input gave non-negative output");

endmodule

### design/gain_tanh_soft_clipper_core.sv
// ----------------------------------------------------------------------------
// gain_tanh_soft_clipper_core
// Gain stage followed by a tanh soft clipper on signed 32-bit samples.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while in_stall is low and returns one result
// beat per sample, in order, after passing through these stages:
// sign split, gain multiply, table lookup, interpolation multiply, round and
// cap, sign restore, one register stage each. Every stage holds its beat
// while the next is full, so a stalled output lets the pipeline fill its
// empty stages before the input is stalled. The gain (unsigned Q8.8, reset
// to unity) is written through the configuration channel, which is always
// ready; write it only while no sample is in flight.
module gain_tanh_soft_clipper_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gtsc_pkg::GAIN_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gtsc_pkg::sample_in_t          in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gtsc_pkg::sample_out_t         out_data
);

    logic [gtsc_pkg::GAIN_W-1:0] gain_reg;

    logic                 in_ready;
    logic                 scaled_valid;
    logic                 scaled_ready;
    gtsc_pkg::scaled_t    scaled_data;
    logic                 seg_valid;
    logic                 seg_ready;
    gtsc_pkg::segment_t   seg_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= gtsc_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gain_reg <= cfg_data;
        end
    end

    assign in_stall = !in_ready;

    gtsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .gain     (gain_reg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_data),
        .dn_valid (scaled_valid),
        .dn_ready (scaled_ready),
        .dn_data  (scaled_data)
    );

    gtsc_lookup u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (scaled_valid),
        .up_ready (scaled_ready),
        .up_data  (scaled_data),
        .dn_valid (seg_valid),
        .dn_ready (seg_ready),
        .dn_data  (seg_data)
    );

    gtsc_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (seg_valid),
        .up_ready (seg_ready),
        .up_data  (seg_data),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_data  (out_data)
    );

endmodule
